// ----- hdl/sdspi_pkg.sv -----
// Shared types, constants and codes for the SPI-mode SD single-block engine.
package sdspi_pkg;

  localparam int BLOCK_BYTES   = 512;
  localparam int R1_WAIT_LIMIT = 256;
  localparam int BYTE_CNT_W    = $clog2(BLOCK_BYTES + 1);
  localparam int R1_CNT_W      = $clog2(R1_WAIT_LIMIT + 1);
  localparam int ELAPSED_W     = 16;
  localparam int TIMEOUT_W     = 15;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 15;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SDHC_MODE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOKEN_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUSY_TIMEOUT  = 2'd2;

  localparam logic [TIMEOUT_W-1:0] TOKEN_TIMEOUT_RST = 15'd1000;
  localparam logic [TIMEOUT_W-1:0] BUSY_TIMEOUT_RST  = 15'd5000;

  // Input word function codes.
  localparam logic [1:0] FUNC_XCHG  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  // Protocol bytes.
  localparam logic [7:0] CMD_PREFIX    = 8'h40;
  localparam logic [7:0] CMD17_READ    = 8'd17;
  localparam logic [7:0] CMD24_WRITE   = 8'd24;
  localparam logic [7:0] CMD_CRC       = 8'h95;
  localparam logic [7:0] DATA_TOKEN    = 8'hFE;
  localparam logic [7:0] IDLE_BYTE     = 8'hFF;
  localparam logic [7:0] RESP_MASK     = 8'h1F;
  localparam logic [7:0] RESP_ACCEPTED = 8'h05;
  localparam int         CMD_BYTES     = 6;
  localparam int         CRC_BYTES     = 2;
  localparam int         SECTOR_SHIFT  = 9;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CMD      = 4'd1,
    PH_R1       = 4'd2,
    PH_RTOKEN   = 4'd3,
    PH_RDATA    = 4'd4,
    PH_RCRC     = 4'd5,
    PH_WTOKEN   = 4'd6,
    PH_WDATA    = 4'd7,
    PH_WCRC     = 4'd8,
    PH_WRESP    = 4'd9,
    PH_BUSY     = 4'd10,
    PH_END_OK   = 4'd11,
    PH_END_FAIL = 4'd12
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] block_index;
    logic [7:0]  miso_byte;
    logic [7:0]  wdata_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       more_exchange;
    logic       cs_asserted;
    logic [7:0] rdata_byte;
    logic       rdata_valid;
    logic       wdata_taken;
    logic       done_res;
    logic       done_ok;
    logic       start_refused;
    logic       idle;
  } out_word_t;

  typedef struct packed {
    logic                 sdhc_mode;
    logic [TIMEOUT_W-1:0] token_timeout_ms;
    logic [TIMEOUT_W-1:0] busy_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic                  is_write;
    logic [BYTE_CNT_W-1:0] byte_count;
    logic [R1_CNT_W-1:0]   r1_wait_count;
    logic [31:0]           command_argument;
    logic [ELAPSED_W-1:0]  elapsed_ms;
  } eng_state_t;

endpackage

// ----- hdl/sdspi_step.sv -----
// Per-word decision logic: next engine state and the result word for one input word.
module sdspi_step (
  input  sdspi_pkg::eng_state_t cur,
  input  sdspi_pkg::cfg_t       cfg,
  input  sdspi_pkg::in_word_t   in_w,
  output sdspi_pkg::eng_state_t nxt,
  output sdspi_pkg::out_word_t  out_w
);

  logic [sdspi_pkg::BYTE_CNT_W-1:0] cnt_inc;
  logic [sdspi_pkg::R1_CNT_W-1:0]   r1_inc;
  logic                             fail;
  logic                             end_ok;
  logic [7:0]                       cmd_op;

  assign cnt_inc = cur.byte_count + 1'b1;
  assign r1_inc  = cur.r1_wait_count + 1'b1;
  assign cmd_op  = sdspi_pkg::CMD_PREFIX |
                   (cur.is_write ? sdspi_pkg::CMD24_WRITE : sdspi_pkg::CMD17_READ);

  always_comb begin
    nxt    = cur;
    fail   = 1'b0;
    end_ok = 1'b0;
    out_w  = '0;
    out_w.mosi_byte = sdspi_pkg::IDLE_BYTE;

    unique case (in_w.func)
      sdspi_pkg::FUNC_READ, sdspi_pkg::FUNC_WRITE: begin
        if (cur.phase != sdspi_pkg::PH_IDLE) begin
          out_w.start_refused = 1'b1;
        end else begin
          nxt.is_write = (in_w.func == sdspi_pkg::FUNC_WRITE);
          nxt.command_argument = cfg.sdhc_mode ? in_w.block_index :
                                 (in_w.block_index << sdspi_pkg::SECTOR_SHIFT);
          nxt.byte_count    = '0;
          nxt.r1_wait_count = '0;
          nxt.elapsed_ms    = '0;
          nxt.phase         = sdspi_pkg::PH_CMD;
          out_w.mosi_byte   = sdspi_pkg::CMD_PREFIX |
                              ((in_w.func == sdspi_pkg::FUNC_WRITE) ?
                               sdspi_pkg::CMD24_WRITE : sdspi_pkg::CMD17_READ);
          out_w.more_exchange = 1'b1;
        end
      end
      sdspi_pkg::FUNC_TICK: begin
        if ((cur.phase == sdspi_pkg::PH_RTOKEN || cur.phase == sdspi_pkg::PH_BUSY) &&
            (cur.elapsed_ms != '1)) begin
          nxt.elapsed_ms = cur.elapsed_ms + 1'b1;
        end
      end
      sdspi_pkg::FUNC_XCHG: begin
        unique case (cur.phase)
          sdspi_pkg::PH_CMD: begin
            nxt.byte_count = cnt_inc;
            if (cnt_inc < sdspi_pkg::BYTE_CNT_W'(sdspi_pkg::CMD_BYTES)) begin
              unique case (cnt_inc[2:0])
                3'd1:    out_w.mosi_byte = cur.command_argument[31:24];
                3'd2:    out_w.mosi_byte = cur.command_argument[23:16];
                3'd3:    out_w.mosi_byte = cur.command_argument[15:8];
                3'd4:    out_w.mosi_byte = cur.command_argument[7:0];
                3'd0:    out_w.mosi_byte = cmd_op;
                default: out_w.mosi_byte = sdspi_pkg::CMD_CRC;
              endcase
            end else begin
              nxt.phase         = sdspi_pkg::PH_R1;
              nxt.r1_wait_count = '0;
            end
            out_w.more_exchange = 1'b1;
          end
          sdspi_pkg::PH_R1: begin
            if (in_w.miso_byte == sdspi_pkg::IDLE_BYTE) begin
              nxt.r1_wait_count = r1_inc;
              if (r1_inc >= sdspi_pkg::R1_CNT_W'(sdspi_pkg::R1_WAIT_LIMIT)) fail = 1'b1;
              else out_w.more_exchange = 1'b1;
            end else if (in_w.miso_byte != 8'd0) begin
              fail = 1'b1;
            end else if (cur.is_write) begin
              nxt.phase           = sdspi_pkg::PH_WTOKEN;
              out_w.mosi_byte     = sdspi_pkg::DATA_TOKEN;
              out_w.more_exchange = 1'b1;
            end else begin
              nxt.phase           = sdspi_pkg::PH_RTOKEN;
              nxt.elapsed_ms      = '0;
              out_w.more_exchange = 1'b1;
            end
          end
          sdspi_pkg::PH_RTOKEN: begin
            if (in_w.miso_byte == sdspi_pkg::DATA_TOKEN) begin
              nxt.phase           = sdspi_pkg::PH_RDATA;
              nxt.byte_count      = '0;
              out_w.more_exchange = 1'b1;
            end else if (cur.elapsed_ms >= {1'b0, cfg.token_timeout_ms}) begin
              fail = 1'b1;
            end else begin
              out_w.more_exchange = 1'b1;
            end
          end
          sdspi_pkg::PH_RDATA: begin
            out_w.rdata_byte  = in_w.miso_byte;
            out_w.rdata_valid = 1'b1;
            nxt.byte_count    = cnt_inc;
            if (cnt_inc >= sdspi_pkg::BYTE_CNT_W'(sdspi_pkg::BLOCK_BYTES)) begin
              nxt.phase      = sdspi_pkg::PH_RCRC;
              nxt.byte_count = '0;
            end
            out_w.more_exchange = 1'b1;
          end
          sdspi_pkg::PH_RCRC: begin
            nxt.byte_count = cnt_inc;
            if (cnt_inc >= sdspi_pkg::BYTE_CNT_W'(sdspi_pkg::CRC_BYTES)) end_ok = 1'b1;
            else out_w.more_exchange = 1'b1;
          end
          sdspi_pkg::PH_WTOKEN: begin
            nxt.phase           = sdspi_pkg::PH_WDATA;
            nxt.byte_count      = '0;
            out_w.mosi_byte     = in_w.wdata_byte;
            out_w.wdata_taken   = 1'b1;
            out_w.more_exchange = 1'b1;
          end
          sdspi_pkg::PH_WDATA: begin
            nxt.byte_count = cnt_inc;
            if (cnt_inc < sdspi_pkg::BYTE_CNT_W'(sdspi_pkg::BLOCK_BYTES)) begin
              out_w.mosi_byte   = in_w.wdata_byte;
              out_w.wdata_taken = 1'b1;
            end else begin
              nxt.phase      = sdspi_pkg::PH_WCRC;
              nxt.byte_count = '0;
            end
            out_w.more_exchange = 1'b1;
          end
          sdspi_pkg::PH_WCRC: begin
            nxt.byte_count = cnt_inc;
            if (cnt_inc >= sdspi_pkg::BYTE_CNT_W'(sdspi_pkg::CRC_BYTES)) begin
              nxt.phase = sdspi_pkg::PH_WRESP;
            end
            out_w.more_exchange = 1'b1;
          end
          sdspi_pkg::PH_WRESP: begin
            if ((in_w.miso_byte & sdspi_pkg::RESP_MASK) != sdspi_pkg::RESP_ACCEPTED) begin
              fail = 1'b1;
            end else begin
              nxt.phase           = sdspi_pkg::PH_BUSY;
              nxt.elapsed_ms      = '0;
              out_w.more_exchange = 1'b1;
            end
          end
          sdspi_pkg::PH_BUSY: begin
            if (in_w.miso_byte != 8'd0) end_ok = 1'b1;
            else if (cur.elapsed_ms >= {1'b0, cfg.busy_timeout_ms}) fail = 1'b1;
            else out_w.more_exchange = 1'b1;
          end
          sdspi_pkg::PH_END_OK, sdspi_pkg::PH_END_FAIL: begin
            out_w.done_res    = 1'b1;
            out_w.done_ok     = (cur.phase == sdspi_pkg::PH_END_OK);
            nxt.phase         = sdspi_pkg::PH_IDLE;
            nxt.byte_count    = '0;
            nxt.r1_wait_count = '0;
            nxt.elapsed_ms    = '0;
          end
          default: begin
            nxt.phase = sdspi_pkg::PH_IDLE;
          end
        endcase
        // Any ending releases chip select and clocks one trailing idle byte.
        if (fail || end_ok) begin
          nxt.phase           = end_ok ? sdspi_pkg::PH_END_OK : sdspi_pkg::PH_END_FAIL;
          out_w.mosi_byte     = sdspi_pkg::IDLE_BYTE;
          out_w.more_exchange = 1'b1;
        end
      end
      default: ;
    endcase

    out_w.cs_asserted = (nxt.phase != sdspi_pkg::PH_IDLE) &&
                        (nxt.phase != sdspi_pkg::PH_END_OK) &&
                        (nxt.phase != sdspi_pkg::PH_END_FAIL);
    out_w.idle        = (nxt.phase == sdspi_pkg::PH_IDLE);
  end

endmodule

// ----- hdl/sd_spi_single_block_transfer.sv -----
// Top level of the SPI-mode SD single-block read/write engine.
//
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/in_stall   sdspi_pkg::in_word_t  (func, block, miso, wdata)
//   out_     output     out_valid/out_stall sdspi_pkg::out_word_t (mosi, flags, rdata)
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// Every word is decided in the cycle it is accepted and its result word is registered
// into the result buffer, and a new word can enter every cycle while in_stall is low.
// The result side is a two-entry buffer; in_stall rises only while both entries are
// held by a stalled consumer. Reset (synchronous, rst_n low) puts the engine in idle,
// empties the buffer and loads the register defaults.
module sd_spi_single_block_transfer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sdspi_pkg::in_word_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sdspi_pkg::out_word_t                 out_data,
  input  logic                                 cfg_we,
  input  logic [sdspi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sdspi_pkg::cfg_t       cfg_r;
  sdspi_pkg::eng_state_t state_r;
  sdspi_pkg::eng_state_t state_nxt;
  sdspi_pkg::out_word_t  res_nxt;
  sdspi_pkg::out_word_t  buf0_r;
  sdspi_pkg::out_word_t  buf1_r;
  logic [1:0]            count_r;
  logic                  push;
  logic                  pop;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sdhc_mode        <= 1'b0;
      cfg_r.token_timeout_ms <= sdspi_pkg::TOKEN_TIMEOUT_RST;
      cfg_r.busy_timeout_ms  <= sdspi_pkg::BUSY_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdspi_pkg::CFG_SDHC_MODE:     cfg_r.sdhc_mode        <= cfg_wdata[0];
        sdspi_pkg::CFG_TOKEN_TIMEOUT: cfg_r.token_timeout_ms <= cfg_wdata;
        sdspi_pkg::CFG_BUSY_TIMEOUT:  cfg_r.busy_timeout_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sdspi_step u_step (
    .cur   (state_r),
    .cfg   (cfg_r),
    .in_w  (in_data),
    .nxt   (state_nxt),
    .out_w (res_nxt)
  );

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = buf0_r;

  // Engine state only advances on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: sdspi_pkg::PH_IDLE, default: '0};
    end else if (push) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Result buffer: buf0_r is the head shown on the output.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count_r == 2'd1) begin
        buf0_r <= res_nxt;
      end else begin
        buf0_r <= buf1_r;
        if (push) buf1_r <= res_nxt;
      end
    end else if (push) begin
      if (count_r == 2'd0) buf0_r <= res_nxt;
      else buf1_r <= res_nxt;
    end
  end

endmodule
